[hdl/audvc_pkg.sv]
// Shared types, codes and constants of the accelerating up/down value counter.
package audvc_pkg;

   localparam int VALUE_W = 32;
   localparam int RATE_W  = 16;
   localparam int OP_W    = 3;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   // Button events
   localparam logic [OP_W-1:0] OP_MORE    = 3'd0;
   localparam logic [OP_W-1:0] OP_LESS    = 3'd1;
   localparam logic [OP_W-1:0] OP_TO_MAX  = 3'd2;
   localparam logic [OP_W-1:0] OP_TO_MIN  = 3'd3;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
   localparam logic [OP_W-1:0] OP_LOAD    = 3'd5;

   // Register indexes, taken from byte address bit 2
   localparam logic REG_LOWER_LIMIT = 1'b0;
   localparam logic REG_UPPER_LIMIT = 1'b1;

   localparam logic signed [VALUE_W-1:0] LOWER_LIMIT_RESET = 32'sd0;
   localparam logic signed [VALUE_W-1:0] UPPER_LIMIT_RESET = 32'sd255;

   // Rate in 8.8 fixed point
   localparam int FRAC_BITS   = 8;
   localparam int STEP_GROWTH = 8;
   localparam int SEED_RATE   = 256 - (20 * STEP_GROWTH);
   localparam int RATE_CAP    = 16384;

   localparam logic signed [RATE_W-1:0] RATE_STEP  = RATE_W'(STEP_GROWTH);
   localparam logic signed [RATE_W-1:0] RATE_SEED  = RATE_W'(SEED_RATE);
   localparam logic signed [RATE_W-1:0] RATE_MAX   = RATE_W'(RATE_CAP);
   localparam logic signed [RATE_W-1:0] RATE_ROUND = RATE_W'((1 << FRAC_BITS) - 1);

   typedef struct packed {
      logic signed [VALUE_W-1:0] lower;
      logic signed [VALUE_W-1:0] upper;
   } limits_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [RATE_W-1:0]  rate;
   } state_type;

endpackage

[hdl/accelerating_updown_value_counter.sv]
// Top level of the accelerating up/down value counter.
// Each button event item passes an input register and one step of logic into the
// result register, so one item is taken every cycle unless the result register is
// full and not taken; its result appears as the item leaves the input register.
// The held value and rate update with the result, so the next item in the input
// register always sees the state left by the one before. The user must write the
// limits through the configuration port while no item is in flight (unenforced).
module accelerating_updown_value_counter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [audvc_pkg::OP_W-1:0]           req_op,
   input  logic signed [audvc_pkg::VALUE_W-1:0] req_start_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [audvc_pkg::VALUE_W-1:0] rsp_current_value,
   output logic signed [audvc_pkg::RATE_W-1:0]  rsp_current_rate,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [audvc_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [audvc_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [audvc_pkg::DATA_W-1:0]         csr_prdata,
   output logic                                 csr_pready
);
   import audvc_pkg::*;

   limits_type                  limits;
   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [OP_W-1:0]             in_op_ff;
   logic signed [VALUE_W-1:0]   in_start_ff;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   state_type                   state_ff;
   state_type                   state_in;
   state_type                   state_nxt;
   logic                        advance;
   logic                        req_fire;

   audvc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .limits      (limits)
   );

   audvc_step u_step (
      .op          (in_op_ff),
      .start_value (in_start_ff),
      .limits      (limits),
      .state_cur   (state_ff),
      .state_nxt   (state_nxt)
   );

   // Move the item forward when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      state_in = advance ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.value <= '0;
         state_ff.rate  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_op_ff    <= req_op;
         in_start_ff <= req_start_value;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_current_value = state_ff.value;
   assign rsp_current_rate  = state_ff.rate;

endmodule

[hdl/audvc_csr.sv]
// Configuration registers: lower and upper limit behind an APB-style port.
module audvc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [audvc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [audvc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [audvc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                          csr_pready,
   output audvc_pkg::limits_type         limits
);
   import audvc_pkg::*;

   limits_type limits_ff;
   limits_type limits_in;
   logic       wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      limits_in = limits_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_LOWER_LIMIT: limits_in.lower = csr_pwdata;
            REG_UPPER_LIMIT: limits_in.upper = csr_pwdata;
            default:         limits_in = limits_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.lower <= LOWER_LIMIT_RESET;
         limits_ff.upper <= UPPER_LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_LOWER_LIMIT: csr_prdata = limits_ff.lower;
         REG_UPPER_LIMIT: csr_prdata = limits_ff.upper;
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign limits     = limits_ff;

endmodule

[hdl/audvc_step.sv]
// Next value and rate for one button event.
module audvc_step (
   input  logic [audvc_pkg::OP_W-1:0]             op,
   input  logic signed [audvc_pkg::VALUE_W-1:0]   start_value,
   input  audvc_pkg::limits_type                  limits,
   input  audvc_pkg::state_type                   state_cur,
   output audvc_pkg::state_type                   state_nxt
);
   import audvc_pkg::*;

   logic signed [RATE_W-1:0]  rate_adj;
   logic signed [RATE_W-1:0]  rate_whole;
   logic signed [VALUE_W:0]   sum;
   logic signed [VALUE_W:0]   upper_x;
   logic signed [VALUE_W:0]   lower_x;
   logic signed [RATE_W-1:0]  rate_up;
   logic signed [RATE_W-1:0]  rate_dn;

   // Rate over 256, truncated toward zero
   assign rate_adj   = state_cur.rate + (state_cur.rate[RATE_W-1] ? RATE_ROUND : '0);
   assign rate_whole = rate_adj >>> FRAC_BITS;

   // Full-precision sum so it never wraps
   assign sum     = {state_cur.value[VALUE_W-1], state_cur.value}
                  + {{(VALUE_W+1-RATE_W){rate_whole[RATE_W-1]}}, rate_whole};
   assign upper_x = {limits.upper[VALUE_W-1], limits.upper};
   assign lower_x = {limits.lower[VALUE_W-1], limits.lower};
   assign rate_up = state_cur.rate + RATE_STEP;
   assign rate_dn = state_cur.rate - RATE_STEP;

   always_comb begin
      state_nxt = state_cur;
      case (op)
         OP_MORE: begin
            if (state_cur.value < limits.upper) begin
               if (state_cur.rate <= 0) begin
                  state_nxt.value = state_cur.value + 32'sd1;
                  state_nxt.rate  = RATE_SEED;
               end else if (sum > upper_x) begin
                  state_nxt.value = limits.upper;
                  state_nxt.rate  = '0;
               end else begin
                  state_nxt.value = sum[VALUE_W-1:0];
                  state_nxt.rate  = (rate_up > RATE_MAX) ? RATE_MAX : rate_up;
               end
            end
         end
         OP_LESS: begin
            if (state_cur.value > limits.lower) begin
               if (state_cur.rate >= 0) begin
                  state_nxt.value = state_cur.value - 32'sd1;
                  state_nxt.rate  = -RATE_SEED;
               end else if (sum < lower_x) begin
                  state_nxt.value = limits.lower;
                  state_nxt.rate  = '0;
               end else begin
                  state_nxt.value = sum[VALUE_W-1:0];
                  state_nxt.rate  = (rate_dn < -RATE_MAX) ? -RATE_MAX : rate_dn;
               end
            end
         end
         OP_TO_MAX: begin
            state_nxt.value = limits.upper;
            state_nxt.rate  = '0;
         end
         OP_TO_MIN: begin
            state_nxt.value = limits.lower;
            state_nxt.rate  = '0;
         end
         OP_RELEASE: begin
            state_nxt.rate = '0;
         end
         OP_LOAD: begin
            state_nxt.value = start_value;
            state_nxt.rate  = '0;
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule
